// ----- rtl/srtc_pkg.sv -----
package srtc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int FIELD_W     = 62;
   localparam int LEN_W       = 64;
   localparam int STATUS_W    = 3;
   localparam int INDEX_W     = 7;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW       = 3'd0,
      ST_JOIN_NEXT = 3'd1,
      ST_JOIN_PREV = 3'd2,
      ST_JOIN_BOTH = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [FIELD_W-1:0] filter_start;
      logic [FIELD_W-1:0] protocol_start;
      logic [FIELD_W-1:0] range_length;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] entry_index;
      logic [INDEX_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] filter_start;
      logic [FIELD_W-1:0] protocol_start;
      logic [LEN_W-1:0]   range_len;
   } entry_type;

   typedef struct packed {
      logic above;
      logic equal;
      logic join_next;
      logic join_prev;
   } flags_type;

   typedef struct packed {
      logic             apply;
      logic             insert;
      logic             join_next;
      logic             join_prev;
      logic [CNT_W-1:0] next_idx;
      logic [CNT_W-1:0] prev_idx;
      logic [CNT_W-1:0] count;
   } update_type;

endpackage

// ----- rtl/sorted_range_table_coalescer.sv -----
// Channel   Ports                          Word
// input     req_valid, req_stall           req_word  (filter_start, protocol_start,
//                                                     range_length)
// result    rsp_valid, rsp_stall           rsp_word  (status, entry_index, entry_count)
//
// One word at a time: after acceptance the word goes through the compare state, a
// binary search over the registered cell compares, and the update state, which
// registers the result. The row of cells registers the compares in the compare state
// and does the shift or join in the update state.
// Reset clears the entry count, the state and the result valid; the cells need no reset.
// A stalled result holds in the output register; the next word is taken meanwhile.
module sorted_range_table_coalescer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  srtc_pkg::req_type  req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output srtc_pkg::rsp_type  rsp_word
);
   import srtc_pkg::*;

   req_type                      item;
   update_type                   update;
   entry_type                    entries [TABLE_DEPTH];
   flags_type [TABLE_DEPTH-1:0]  cell_flags;

   srtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .cell_flags (cell_flags),
      .item       (item),
      .update     (update)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type left;

      if (i == 0) begin : g_first
         assign left = '0;
      end else begin : g_rest
         assign left = entries[i-1];
      end

      srtc_cell u_cell (
         .clock      (clock),
         .cell_index (CNT_W'(i)),
         .item       (item),
         .update     (update),
         .left_entry (left),
         .entry      (entries[i]),
         .flags      (cell_flags[i])
      );
   end

endmodule

// ----- rtl/srtc_cell.sv -----
module srtc_cell (
   input  logic                        clock,
   input  logic [srtc_pkg::CNT_W-1:0]  cell_index,
   input  srtc_pkg::req_type           item,
   input  srtc_pkg::update_type        update,
   input  srtc_pkg::entry_type         left_entry,
   output srtc_pkg::entry_type         entry,
   output srtc_pkg::flags_type         flags
);
   import srtc_pkg::*;

   entry_type        entry_ff, entry_in;
   flags_type        flags_ff, flags_in;
   logic [LEN_W-1:0] key_w, ps_w, fs_w, ps_new_w, ln_w;
   logic             hit_next, hit_prev;

   always_comb begin
      key_w    = LEN_W'(entry_ff.filter_start);
      ps_w     = LEN_W'(entry_ff.protocol_start);
      fs_w     = LEN_W'(item.filter_start);
      ps_new_w = LEN_W'(item.protocol_start);
      ln_w     = LEN_W'(item.range_length);

      flags_in.above     = item.filter_start > entry_ff.filter_start;
      flags_in.equal     = item.filter_start == entry_ff.filter_start;
      flags_in.join_next = ((fs_w + ln_w) == key_w) && ((ps_new_w + ln_w) == ps_w);
      flags_in.join_prev = ((key_w + entry_ff.range_len) == fs_w) &&
                           ((ps_w + entry_ff.range_len) == ps_new_w);

      hit_next = update.join_next && (update.next_idx == cell_index);
      hit_prev = update.join_prev && (update.prev_idx == cell_index);

      entry_in = entry_ff;
      if (update.apply) begin
         if (update.insert) begin
            if (cell_index == update.next_idx) begin
               entry_in.filter_start   = item.filter_start;
               entry_in.protocol_start = item.protocol_start;
               entry_in.range_len      = ln_w;
            end else if ((cell_index > update.next_idx) && (cell_index <= update.count)) begin
               entry_in = left_entry;
            end
         end else begin
            // a join at either end grows the length by the new range
            if (hit_next) begin
               entry_in.filter_start   = item.filter_start;
               entry_in.protocol_start = item.protocol_start;
            end
            if (hit_next || hit_prev) begin
               entry_in.range_len = entry_ff.range_len + ln_w;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

// ----- rtl/srtc_ctrl.sv -----
module srtc_ctrl (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_stall,
   input  srtc_pkg::req_type                                req_word,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output srtc_pkg::rsp_type                                rsp_word,
   input  srtc_pkg::flags_type [srtc_pkg::TABLE_DEPTH-1:0]  cell_flags,
   output srtc_pkg::req_type                                item,
   output srtc_pkg::update_type                             update
);
   import srtc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_SEARCH,
      S_UPDATE
   } state_type;

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hip1_ff, hip1_in;
   logic [CNT_W-1:0] next_ff, next_in;
   logic [CNT_W-1:0] prev_ff, prev_in;
   logic             prev_ok_ff, prev_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff, rsp_word_in;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic             out_free, join_next, join_prev, full;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hip1_in      = hip1_ff;
      next_in      = next_ff;
      prev_in      = prev_ff;
      prev_ok_in   = prev_ok_ff;
      rsp_word_in  = rsp_word_ff;

      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // hip1 holds the upper search bound plus one, so it never goes negative
      mid_sum = {1'b0, lo_ff} + {1'b0, hip1_ff} - (CNT_W + 1)'(1);
      mid     = IDX_W'(mid_sum >> 1);

      join_next = (next_ff < count_ff) && cell_flags[IDX_W'(next_ff)].join_next;
      join_prev = prev_ok_ff && cell_flags[IDX_W'(prev_ff)].join_prev;
      full      = (count_ff == CNT_W'(TABLE_DEPTH));

      update.apply     = 1'b0;
      update.insert    = !join_next && !join_prev && !full;
      update.join_next = join_next;
      update.join_prev = join_prev;
      update.next_idx  = next_ff;
      update.prev_idx  = prev_ff;
      update.count     = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            lo_in    = '0;
            hip1_in  = count_ff;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (lo_ff < hip1_ff) begin
               if (cell_flags[mid].equal) begin
                  next_in    = CNT_W'(mid);
                  prev_in    = CNT_W'(mid);
                  prev_ok_in = 1'b1;
                  state_in   = S_UPDATE;
               end else if (cell_flags[mid].above) begin
                  lo_in = CNT_W'(mid) + CNT_W'(1);
               end else begin
                  hip1_in = CNT_W'(mid);
               end
            end else begin
               next_in    = lo_ff;
               prev_in    = hip1_ff - CNT_W'(1);
               prev_ok_in = (hip1_ff != '0);
               state_in   = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // hold until the output register is free
            if (out_free) begin
               update.apply = 1'b1;
               if (update.insert) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (join_next && join_prev) begin
                  rsp_word_in.status = ST_JOIN_BOTH;
               end else if (join_next) begin
                  rsp_word_in.status = ST_JOIN_NEXT;
               end else if (join_prev) begin
                  rsp_word_in.status = ST_JOIN_PREV;
               end else if (full) begin
                  rsp_word_in.status = ST_FULL;
               end else begin
                  rsp_word_in.status = ST_NEW;
               end
               rsp_word_in.entry_index = (join_prev && !join_next) ? INDEX_W'(prev_ff)
                                                                   : INDEX_W'(next_ff);
               rsp_word_in.entry_count = INDEX_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      lo_ff       <= lo_in;
      hip1_ff     <= hip1_in;
      next_ff     <= next_in;
      prev_ff     <= prev_in;
      prev_ok_ff  <= prev_ok_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign item      = item_ff;

endmodule

// ----- rtl/srtc_checker.sv -----
module srtc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  srtc_pkg::rsp_type  rsp_word
);
   import srtc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again straight after a word");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_FULL) |->
         rsp_word.entry_count == INDEX_W'(TABLE_DEPTH))
      else $error("table full reported below depth");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_FULL) |->
         rsp_word.entry_index < rsp_word.entry_count)
      else $error("entry index beyond entry count");

endmodule

bind sorted_range_table_coalescer srtc_checker u_srtc_checker (.*);
